// ===== hw/rtl/acl_pkg.sv =====
// Shared types and constants for the access control list check block.
package acl_pkg;

  localparam int ACL_SID_W  = 32;
  localparam int ACL_MASK_W = 32;
  localparam int ACL_GCNT_W = 3;
  localparam int ACL_DATA_W = 32;
  localparam int ACL_ADDR_W = 5;
  localparam int ACL_REG_W  = 3;

  // Configuration register map, one word per register
  typedef enum logic [ACL_REG_W-1:0] {
    REG_OWNER_SID    = 3'd0,
    REG_GROUP_SID_A  = 3'd1,
    REG_GROUP_SID_B  = 3'd2,
    REG_GROUP_SID_C  = 3'd3,
    REG_GROUP_SID_D  = 3'd4,
    REG_GROUP_COUNT  = 3'd5,
    REG_BYPASS_ACL   = 3'd6,
    REG_EVERYONE_SID = 3'd7
  } acl_reg_t;

  typedef logic [ACL_SID_W-1:0]  acl_sid_t;
  typedef logic [ACL_MASK_W-1:0] acl_mask_t;

endpackage

// ===== hw/rtl/acl_sid_match.sv =====
// Compare one entry id against the caller's owner, everyone and active group ids.
module acl_sid_match
  import acl_pkg::*;
#(
  parameter int MAX_GROUPS = 4
) (
  input  acl_sid_t               entry_sid,
  input  acl_sid_t               owner_sid,
  input  acl_sid_t               everyone_sid,
  input  acl_sid_t               group_sid [MAX_GROUPS],
  input  logic [ACL_GCNT_W-1:0]  group_count,
  output logic                   hit
);

  logic [MAX_GROUPS-1:0] group_hit;

  // Count a group only when it lies below the active count
  always_comb begin
    for (int k = 0; k < MAX_GROUPS; k++) begin
      group_hit[k] = (group_count > ACL_GCNT_W'(k)) && (group_sid[k] == entry_sid);
    end
  end

  assign hit = (entry_sid == everyone_sid) || (entry_sid == owner_sid) || (|group_hit);

endmodule

// ===== hw/rtl/acl_access_check_unit.sv =====
// Top level of the access control list check block.
//
// Usage: the caller's identity (owner id, group ids, group count, bypass flag,
// everyone id) is written over the APB-style port while the block is idle.
// A list is then streamed on the in_ channel, one entry per transaction; the
// transaction marked in_last_entry closes the check and yields one result on
// the out_ channel. A transaction with in_no_list set yields a result at once.
// A result appears on out_granted_access in the cycle after the
// transaction that causes it is accepted.
// Throughput: one transaction per cycle while no held result is stalled; the
// entry compare and mask update are a single pass of logic between the input
// handshake and the result register.
// The input stalls only while a result sits in the result register and the
// receiver stalls it; the result then holds until taken.
// Reset clears the configuration registers, both access masks and the result
// valid flag.
module acl_access_check_unit
  import acl_pkg::*;
#(
  parameter int MAX_GROUPS = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ACL_ADDR_W-1:0]  paddr,
  input  logic [ACL_DATA_W-1:0]  pwdata,
  output logic [ACL_DATA_W-1:0]  prdata,
  output logic                   pready,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_no_list,
  input  logic                   in_entry_valid,
  input  acl_sid_t               in_entry_sid,
  input  logic                   in_entry_is_deny,
  input  acl_mask_t              in_entry_mask,
  input  acl_mask_t              in_desired_access,
  input  logic                   in_last_entry,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output acl_mask_t              out_granted_access
);

  acl_sid_t               owner_sid_r;
  acl_sid_t               everyone_sid_r;
  acl_sid_t               group_sid_r [MAX_GROUPS];
  logic [ACL_GCNT_W-1:0]  group_count_r;
  logic                   bypass_acl_r;

  acl_mask_t              allowed_r, allowed_nxt;
  acl_mask_t              denied_r, denied_nxt;
  logic                   out_valid_r, out_valid_nxt;
  acl_mask_t              granted_r, granted_nxt;

  acl_reg_t               reg_idx;
  logic                   cfg_wr;
  logic                   in_accept;
  logic                   sid_hit;
  logic                   entry_hit;
  acl_mask_t              allowed_mix;
  acl_mask_t              denied_mix;

  assign pready  = 1'b1;
  assign reg_idx = acl_reg_t'(paddr[ACL_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_sid_r    <= '0;
      everyone_sid_r <= '0;
      group_count_r  <= '0;
      bypass_acl_r   <= 1'b0;
      for (int k = 0; k < MAX_GROUPS; k++) begin
        group_sid_r[k] <= '0;
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_OWNER_SID:    owner_sid_r    <= pwdata[ACL_SID_W-1:0];
        REG_EVERYONE_SID: everyone_sid_r <= pwdata[ACL_SID_W-1:0];
        REG_GROUP_COUNT:  group_count_r  <= pwdata[ACL_GCNT_W-1:0];
        REG_BYPASS_ACL:   bypass_acl_r   <= pwdata[0];
        default: begin
        end
      endcase
      for (int k = 0; k < MAX_GROUPS; k++) begin
        if (reg_idx == acl_reg_t'(REG_GROUP_SID_A + ACL_REG_W'(k))) begin
          group_sid_r[k] <= pwdata[ACL_SID_W-1:0];
        end
      end
    end
  end

  // Read back configuration
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_OWNER_SID:    prdata = ACL_DATA_W'(owner_sid_r);
      REG_EVERYONE_SID: prdata = ACL_DATA_W'(everyone_sid_r);
      REG_GROUP_COUNT:  prdata = ACL_DATA_W'(group_count_r);
      REG_BYPASS_ACL:   prdata = ACL_DATA_W'(bypass_acl_r);
      default:          prdata = '0;
    endcase
    for (int k = 0; k < MAX_GROUPS; k++) begin
      if (reg_idx == acl_reg_t'(REG_GROUP_SID_A + ACL_REG_W'(k))) begin
        prdata = ACL_DATA_W'(group_sid_r[k]);
      end
    end
  end

  acl_sid_match #(
    .MAX_GROUPS (MAX_GROUPS)
  ) u_match (
    .entry_sid    (in_entry_sid),
    .owner_sid    (owner_sid_r),
    .everyone_sid (everyone_sid_r),
    .group_sid    (group_sid_r),
    .group_count  (group_count_r),
    .hit          (sid_hit)
  );

  // Stall only when a held result cannot drain
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign entry_hit = in_entry_valid && sid_hit;

  // Fold the current entry into the masks
  assign allowed_mix = allowed_r | ((entry_hit && !in_entry_is_deny) ? in_entry_mask : '0);
  assign denied_mix  = denied_r  | ((entry_hit &&  in_entry_is_deny) ? in_entry_mask : '0);

  always_comb begin
    allowed_nxt   = allowed_r;
    denied_nxt    = denied_r;
    granted_nxt   = granted_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (in_accept) begin
      if (in_no_list) begin
        allowed_nxt   = '0;
        denied_nxt    = '0;
        granted_nxt   = in_desired_access;
        out_valid_nxt = 1'b1;
      end else if (in_last_entry) begin
        allowed_nxt   = '0;
        denied_nxt    = '0;
        granted_nxt   = bypass_acl_r ? in_desired_access
                                     : (allowed_mix & ~denied_mix & in_desired_access);
        out_valid_nxt = 1'b1;
      end else begin
        allowed_nxt = allowed_mix;
        denied_nxt  = denied_mix;
      end
    end
  end

  // Hold masks and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allowed_r   <= '0;
      denied_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      allowed_r   <= allowed_nxt;
      denied_r    <= denied_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    granted_r <= granted_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_granted_access = granted_r;

endmodule

// ===== hw/rtl/acl_checker.sv =====
// Port-level checks for the access control list check block, bound to the top level.
module acl_checker
  import acl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   pready,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic                   in_no_list,
  input  logic                   in_last_entry,
  input  acl_mask_t              in_desired_access,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  acl_mask_t              out_granted_access
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_granted_access))
    else $error("stalled result changed");

  // Pass desired access straight through when there is no list
  a_no_list: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_no_list
    |=> out_valid && out_granted_access == $past(in_desired_access))
    else $error("no-list transaction did not grant desired access");

  // Grant only bits that were asked for
  a_subset: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_entry
    |=> out_valid && ((out_granted_access & ~$past(in_desired_access)) == '0))
    else $error("granted bits outside desired access");

  // Drop the result flag for a mid-list entry when the receiver drains
  a_mid_list: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_no_list && !in_last_entry && !out_stall |=> !out_valid)
    else $error("result invented for a mid-list entry");

  // Clear the result on reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid && pready)
    else $error("result valid after reset");

endmodule

bind acl_access_check_unit acl_checker u_acl_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .pready             (pready),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_no_list         (in_no_list),
  .in_last_entry      (in_last_entry),
  .in_desired_access  (in_desired_access),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_granted_access (out_granted_access)
);

// ===== verif/acl_access_check_unit_tb.sv =====
// Testbench for the access control list check unit: directed and random lists against a predictor.
`timescale 1ns / 100ps

module acl_access_check_unit_tb;
  import acl_pkg::*;

  localparam int TOKEN_GROUPS = 4;
  localparam int CLK_PERIOD = 12;
  localparam int RUN_LIMIT_NS = 5_000_000;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct {
    logic      no_list;
    logic      entry_valid;
    acl_sid_t  sid;
    logic      is_deny;
    acl_mask_t mask;
    acl_mask_t desired;
    logic      last;
  } acl_item_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ACL_ADDR_W-1:0] paddr;
  logic [ACL_DATA_W-1:0] pwdata;
  logic [ACL_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_no_list;
  logic                  in_entry_valid;
  acl_sid_t              in_entry_sid;
  logic                  in_entry_is_deny;
  acl_mask_t             in_entry_mask;
  acl_mask_t             in_desired_access;
  logic                  in_last_entry;
  logic                  out_valid;
  logic                  out_stall;
  acl_mask_t             out_granted_access;

  // Token identity as the block should hold it
  acl_sid_t              tok_owner;
  acl_sid_t              tok_group [TOKEN_GROUPS];
  logic [ACL_GCNT_W-1:0] tok_group_cnt;
  logic                  tok_bypass;
  acl_sid_t              tok_everyone;

  // Access masks gathered over the open list
  acl_mask_t allow_acc;
  acl_mask_t deny_acc;

  acl_mask_t granted_q[$];

  int  fail_count;
  int  items_sent;
  int  lists_sent;
  int  grants_checked;
  int  identity_loads;
  int  input_held_cycles;
  bit  tx_gaps;
  bit  rx_gaps;
  int  hold_left;

  acl_access_check_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_no_list         (in_no_list),
    .in_entry_valid     (in_entry_valid),
    .in_entry_sid       (in_entry_sid),
    .in_entry_is_deny   (in_entry_is_deny),
    .in_entry_mask      (in_entry_mask),
    .in_desired_access  (in_desired_access),
    .in_last_entry      (in_last_entry),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_granted_access (out_granted_access)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  // Store a register write in the identity copy; return what a read gives back
  function automatic logic [ACL_DATA_W-1:0] store_reg(acl_reg_t r, logic [ACL_DATA_W-1:0] v);
    case (r)
      REG_OWNER_SID: begin
        tok_owner = v;
        return v;
      end
      REG_GROUP_SID_A: begin
        tok_group[0] = v;
        return v;
      end
      REG_GROUP_SID_B: begin
        tok_group[1] = v;
        return v;
      end
      REG_GROUP_SID_C: begin
        tok_group[2] = v;
        return v;
      end
      REG_GROUP_SID_D: begin
        tok_group[3] = v;
        return v;
      end
      REG_GROUP_COUNT: begin
        tok_group_cnt = v[ACL_GCNT_W-1:0];
        return {{(ACL_DATA_W-ACL_GCNT_W){1'b0}}, tok_group_cnt};
      end
      REG_BYPASS_ACL: begin
        tok_bypass = v[0];
        return {{(ACL_DATA_W-1){1'b0}}, tok_bypass};
      end
      REG_EVERYONE_SID: begin
        tok_everyone = v;
        return v;
      end
      default: return '0;
    endcase
  endfunction

  function automatic bit sid_in_token(acl_sid_t sid);
    int lim;
    lim = (tok_group_cnt > TOKEN_GROUPS) ? TOKEN_GROUPS : int'(tok_group_cnt);
    if (sid == tok_everyone || sid == tok_owner) return 1'b1;
    for (int k = 0; k < lim; k++)
      if (tok_group[k] == sid) return 1'b1;
    return 1'b0;
  endfunction

  // Fold one transaction into the masks; return 1 with the grant when a result is due
  function automatic bit grant_for_entry(acl_item_t it, output acl_mask_t granted);
    granted = '0;
    if (it.no_list) begin
      allow_acc = '0;
      deny_acc  = '0;
      granted   = it.desired;
      return 1'b1;
    end
    if (it.entry_valid && sid_in_token(it.sid)) begin
      if (it.is_deny) deny_acc |= it.mask;
      else allow_acc |= it.mask;
    end
    if (!it.last) return 1'b0;
    granted   = tok_bypass ? it.desired : (allow_acc & ~deny_acc & it.desired);
    allow_acc = '0;
    deny_acc  = '0;
    return 1'b1;
  endfunction

  function automatic acl_item_t mk_item(logic nl, logic ev, acl_sid_t sid, logic dn,
                                        acl_mask_t m, acl_mask_t des, logic lst);
    acl_item_t it;
    it.no_list     = nl;
    it.entry_valid = ev;
    it.sid         = sid;
    it.is_deny     = dn;
    it.mask        = m;
    it.desired     = des;
    it.last        = lst;
    return it;
  endfunction

  // Random word biased toward the all-zero and all-one extremes
  function automatic logic [31:0] rand_word();
    int r;
    r = $urandom_range(15);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Mostly ids the token holds, some foreign ones
  function automatic acl_sid_t pick_sid();
    int r;
    r = $urandom_range(9);
    case (r)
      0: return tok_owner;
      1: return tok_everyone;
      2, 3, 4, 5: return tok_group[r-2];
      default: return $urandom;
    endcase
  endfunction

  // Offer one transaction, hold it until taken, then predict its result
  task automatic send_item(acl_item_t it);
    acl_mask_t g;
    if (tx_gaps && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_no_list        <= it.no_list;
    in_entry_valid    <= it.entry_valid;
    in_entry_sid      <= it.sid;
    in_entry_is_deny  <= it.is_deny;
    in_entry_mask     <= it.mask;
    in_desired_access <= it.desired;
    in_last_entry     <= it.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (grant_for_entry(it, g)) granted_q.push_back(g);
  endtask

  // Drop valid and wait until every expected grant is out, plus the block latency
  task automatic wait_idle();
    int n;
    in_valid <= 1'b0;
    n = 0;
    while (granted_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(acl_reg_t r, logic [ACL_DATA_W-1:0] v);
    logic [ACL_DATA_W-1:0] unused;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    unused = store_reg(r, v);
    // idle between accesses
    @(posedge clk);
  endtask

  task automatic apb_read_check(acl_reg_t r);
    logic [ACL_DATA_W-1:0] exp_val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {r, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (r)
      REG_GROUP_COUNT: exp_val = {{(ACL_DATA_W-ACL_GCNT_W){1'b0}}, tok_group_cnt};
      REG_BYPASS_ACL:  exp_val = {{(ACL_DATA_W-1){1'b0}}, tok_bypass};
      REG_OWNER_SID:   exp_val = tok_owner;
      REG_EVERYONE_SID: exp_val = tok_everyone;
      default:         exp_val = tok_group[int'(r) - int'(REG_GROUP_SID_A)];
    endcase
    if (prdata !== exp_val) begin
      $error("%s readback mismatch: expected %h, actual %h", r.name(), exp_val, prdata);
      fail_count++;
    end
    // idle between accesses
    @(posedge clk);
  endtask

  task automatic load_identity(acl_sid_t own, acl_sid_t ga, acl_sid_t gb, acl_sid_t gc,
                               acl_sid_t gd, logic [ACL_GCNT_W-1:0] cnt, logic byp,
                               acl_sid_t every);
    apb_write(REG_OWNER_SID, own);
    apb_write(REG_GROUP_SID_A, ga);
    apb_write(REG_GROUP_SID_B, gb);
    apb_write(REG_GROUP_SID_C, gc);
    apb_write(REG_GROUP_SID_D, gd);
    apb_write(REG_GROUP_COUNT, cnt);
    apb_write(REG_BYPASS_ACL, byp);
    apb_write(REG_EVERYONE_SID, every);
    identity_loads++;
  endtask

  // Write every register with all ones, then with zeros and bit patterns, and read each back
  task automatic test_register_access();
    acl_reg_t r;
    load_identity('1, '1, '1, '1, '1, 3'd7, 1'b1, '1);
    r = r.first();
    do begin
      apb_read_check(r);
      r = r.next();
    end while (r != r.first());
    load_identity('0, 32'h1234_5678, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h8000_0001,
                  3'd0, 1'b0, 32'h0000_0000);
    r = r.first();
    do begin
      apb_read_check(r);
      r = r.next();
    end while (r != r.first());
  endtask

  // Short directed lists covering each special case
  task automatic test_directed_lists();
    load_identity(32'hFFFF_FFFF, 32'h1234_5678, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                  32'h8000_0001, 3'd2, 1'b0, 32'h0000_0000);
    // allow and deny from owner, active groups and everyone; last entry counts
    send_item(mk_item(0, 1, 32'hFFFF_FFFF, 0, 32'hFFFF_0000, 32'h0, 0));
    send_item(mk_item(0, 1, 32'h1234_5678, 0, 32'h0000_FFFF, 32'h0, 0));
    send_item(mk_item(0, 1, 32'hA5A5_A5A5, 1, 32'h0000_00FF, 32'h0, 0));
    send_item(mk_item(0, 1, 32'h5A5A_5A5A, 1, 32'hFFFF_FFFF, 32'h0, 0));
    send_item(mk_item(0, 1, 32'h0000_0000, 1, 32'h0F00_0000, 32'hFFFF_FFFF, 1));
    // empty list
    send_item(mk_item(0, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    // invalid entry carrying a matching id adds nothing
    send_item(mk_item(0, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 32'h0, 0));
    send_item(mk_item(0, 1, 32'hFFFF_FFFF, 0, 32'h0000_0001, 32'h0000_0003, 1));
    // no list in the middle of an open list clears the masks
    send_item(mk_item(0, 1, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 32'h0, 0));
    send_item(mk_item(1, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 0));
    send_item(mk_item(0, 0, 32'h0, 0, 32'h0, 32'hFFFF_FFFF, 1));
    send_item(mk_item(1, 0, 32'h0, 0, 32'h0, 32'hFFFF_FFFF, 1));
    wait_idle();
    // group count above the group registers counts as all four
    apb_write(REG_GROUP_COUNT, 3'd7);
    send_item(mk_item(0, 1, 32'h8000_0001, 0, 32'hAAAA_5555, 32'hFFFF_FFFF, 1));
    send_item(mk_item(0, 1, 32'h7777_7777, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    wait_idle();
    // bypass grants desired regardless of deny entries
    apb_write(REG_BYPASS_ACL, 1'b1);
    send_item(mk_item(0, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    send_item(mk_item(0, 1, 32'hFFFF_FFFF, 0, 32'h0000_00F0, 32'h0, 0));
    send_item(mk_item(0, 0, 32'h0, 0, 32'h0, 32'h1357_9BDF, 1));
    wait_idle();
    apb_write(REG_BYPASS_ACL, 1'b0);
    lists_sent += 12;
  endtask

  // One list of random content, or a stray no-list or empty transaction
  task automatic send_random_list();
    int r;
    int len;
    r = $urandom_range(99);
    lists_sent++;
    if (r < 8) begin
      send_item(mk_item(1, $urandom_range(1), $urandom, $urandom_range(1), $urandom,
                        rand_word(), $urandom_range(1)));
    end else if (r < 14) begin
      send_item(mk_item(0, 0, $urandom, $urandom_range(1), $urandom, rand_word(), 1));
    end else begin
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++)
        send_item(mk_item(0, $urandom_range(9) != 0, pick_sid(), $urandom_range(2) == 0,
                          rand_word(), rand_word(), k == len - 1));
    end
  endtask

  // Stall the receiver long enough that the block backs up into its input
  task automatic test_backpressure();
    tx_gaps   = 1'b0;
    hold_left = 80;
    for (int k = 0; k < 30; k++)
      send_item(mk_item(0, 1, pick_sid(), k % 3 == 0, rand_word(), rand_word(), k % 2 == 1));
    lists_sent += 15;
    wait_idle();
    tx_gaps = 1'b1;
  endtask

  task automatic test_random_lists(int phase, int n_items);
    int goal;
    case (phase)
      0: load_identity('0, '0, '0, '0, '0, 3'd0, 1'b0, '0);
      1: load_identity('1, '1, '1, '1, '1, 3'd7, 1'b1, '1);
      2: load_identity($urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom_range(0, 4), 1'b0, $urandom);
      3: load_identity($urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom_range(5, 7), 1'b0, $urandom);
      default: load_identity($urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom_range(0, 7), $urandom_range(1), $urandom);
    endcase
    // one phase runs flat out on both sides
    tx_gaps = (phase != 2);
    rx_gaps = (phase != 2);
    goal = items_sent + n_items;
    while (items_sent < goal) send_random_list();
    wait_idle();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (rx_gaps) begin
        out_stall <= ($urandom_range(99) < 23);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted grant with the oldest prediction
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall) input_held_cycles++;
      if (out_valid && !out_stall) begin
        if (granted_q.size() == 0) begin
          $error("granted_access with no prediction pending: actual %h", out_granted_access);
          fail_count++;
        end else begin
          acl_mask_t exp_g;
          exp_g = granted_q.pop_front();
          grants_checked++;
          if (out_granted_access !== exp_g) begin
            $error("granted_access mismatch: expected %h, actual %h", exp_g,
                   out_granted_access);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    fail_count        = 0;
    items_sent        = 0;
    lists_sent        = 0;
    grants_checked    = 0;
    identity_loads    = 0;
    input_held_cycles = 0;
    hold_left         = 0;
    tx_gaps           = 1'b1;
    rx_gaps           = 1'b1;
    tok_owner         = '0;
    tok_group         = '{default: '0};
    tok_group_cnt     = '0;
    tok_bypass        = 1'b0;
    tok_everyone      = '0;
    allow_acc         = '0;
    deny_acc          = '0;
    rst_n             <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_valid          <= 1'b0;
    in_no_list        <= 1'b0;
    in_entry_valid    <= 1'b0;
    in_entry_sid      <= '0;
    in_entry_is_deny  <= 1'b0;
    in_entry_mask     <= '0;
    in_desired_access <= '0;
    in_last_entry     <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_access();
    test_directed_lists();
    test_backpressure();
    for (int p = 0; p < 5; p++) test_random_lists(p, 240);

    if (granted_q.size() != 0) begin
      $error("granted_access: %0d predictions never produced", granted_q.size());
      fail_count++;
    end
    $display("Ran %0d transactions in about %0d lists under %0d identity settings;",
             items_sent, lists_sent, identity_loads);
    $display("checked %0d grants, input held back for %0d cycles by result stalls.",
             grants_checked, input_held_cycles);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
